// ----- rtl/core/cmvg_pkg.sv -----
`timescale 1ns / 1ps

package cmvg_pkg;

    // Angles: 2^24 units per half turn
    localparam int ANG_W     = 27;
    localparam int CORDIC_N  = 18;
    localparam int CORDIC_W  = 34;
    localparam int VEC_W     = 38;
    localparam int QUARTER   = 8388608;
    localparam int HALF      = 16777216;
    localparam int FULL      = 33554432;
    localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032875;

    localparam logic signed [ANG_W-1:0] ATAN [CORDIC_N] = '{
        27'sd4194304, 27'sd2476042, 27'sd1308273, 27'sd664100, 27'sd333339,
        27'sd166832, 27'sd83436, 27'sd41721, 27'sd20861, 27'sd10430,
        27'sd5215, 27'sd2608, 27'sd1304, 27'sd652, 27'sd326, 27'sd163,
        27'sd81, 27'sd41
    };

    // divider: three lanes, 25 quotient bits after the whole-part fold
    localparam int DIV_LANES = 3;
    localparam int DIV_STEPS = 25;

    typedef enum logic
    {
        CFG_SEGMENTS = 1'b0,
        CFG_HEIGHT   = 1'b1
    } cfg_idx_t;

    typedef struct packed
    {
        logic err;
        logic upper;
    } div_side_t;

    typedef struct packed
    {
        logic        err;
        logic        upper;
        logic [16:0] tex_u;
    } trig_side_t;

    typedef struct packed
    {
        logic               err;
        logic        [16:0] tex_u;
        logic signed [15:0] px;
        logic signed [18:0] py;
        logic signed [15:0] pz;
        logic signed [15:0] ct;
        logic signed [15:0] cp;
        logic signed [15:0] nsp;
    } vec_side_t;

endpackage

// ----- rtl/core/cmvg_div.sv -----
`timescale 1ns / 1ps

// Three-lane restoring divider: q = a*2^25 + lo over d, a <= d.
// Whole part folded in stage 0, then five quotient bits per stage.
module cmvg_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [7:0]            a    [cmvg_pkg::DIV_LANES],
    input  logic [24:0]           lo   [cmvg_pkg::DIV_LANES],
    input  logic [7:0]            d,
    input  cmvg_pkg::div_side_t   side_in,
    output logic                  out_valid,
    output logic [25:0]           q    [cmvg_pkg::DIV_LANES],
    output cmvg_pkg::div_side_t   side_out
);

    localparam int LANES  = cmvg_pkg::DIV_LANES;
    localparam int STEPS  = cmvg_pkg::DIV_STEPS;
    localparam int PER    = 5;
    localparam int STAGES = STEPS / PER;

    logic [STAGES:0]      v_reg;
    logic [7:0]           d_reg    [STAGES+1];
    cmvg_pkg::div_side_t  side_reg [STAGES+1];
    logic [LANES-1:0]     hi_reg   [STAGES+1];
    logic [7:0]           rem_reg  [STAGES+1][LANES];
    logic [24:0]          lo_reg   [STAGES+1][LANES];
    logic [24:0]          qp_reg   [STAGES+1][LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[STAGES-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0]    <= d;
            side_reg[0] <= side_in;
            for (int l = 0; l < LANES; l++)
            begin
                hi_reg[0][l]  <= (a[l] == d);
                rem_reg[0][l] <= (a[l] == d) ? 8'd0 : a[l];
                lo_reg[0][l]  <= lo[l];
                qp_reg[0][l]  <= '0;
            end
        end
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [7:0]  rem_c [LANES][PER+1];
        logic [24:0] qp_c  [LANES][PER+1];
        logic [8:0]  t_c   [LANES][PER];

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_c[l][0] = rem_reg[s][l];
                qp_c[l][0]  = qp_reg[s][l];
                for (int k = 0; k < PER; k++)
                begin
                    t_c[l][k] = {rem_c[l][k], lo_reg[s][l][STEPS-1-s*PER-k]};
                    if (t_c[l][k] >= {1'b0, d_reg[s]})
                    begin
                        rem_c[l][k+1] = 8'(t_c[l][k] - {1'b0, d_reg[s]});
                        qp_c[l][k+1]  = qp_c[l][k] | (25'd1 << (STEPS-1-s*PER-k));
                    end
                    else
                    begin
                        rem_c[l][k+1] = t_c[l][k][7:0];
                        qp_c[l][k+1]  = qp_c[l][k];
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[s+1]    <= d_reg[s];
                side_reg[s+1] <= side_reg[s];
                hi_reg[s+1]   <= hi_reg[s];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s+1][l] <= rem_c[l][PER];
                    lo_reg[s+1][l]  <= lo_reg[s][l];
                    qp_reg[s+1][l]  <= qp_c[l][PER];
                end
            end
        end
    end

    // fold leaves qp below 2^25, so the whole bit simply sits on top
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            q[l] = {hi_reg[STAGES][l], qp_reg[STAGES][l]};
    end

    assign out_valid = v_reg[STAGES];
    assign side_out  = side_reg[STAGES];

endmodule

// ----- rtl/core/cmvg_sincos.sv -----
`timescale 1ns / 1ps

// Two-lane rotation CORDIC, Q30 inside, Q14 out. Quadrant fold in stage 0,
// three micro-rotations per stage, rounding in the last stage.
module cmvg_sincos
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [25:0]                 angle [2],
    input  cmvg_pkg::trig_side_t        side_in,
    output logic                        out_valid,
    output logic signed [15:0]          sin_q [2],
    output logic signed [15:0]          cos_q [2],
    output cmvg_pkg::trig_side_t        side_out
);

    localparam int LANES  = 2;
    localparam int PER    = 3;
    localparam int STAGES = cmvg_pkg::CORDIC_N / PER;
    localparam int CW     = cmvg_pkg::CORDIC_W;
    localparam int ZW     = cmvg_pkg::ANG_W;

    function automatic logic signed [15:0] rnd_q14(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] m;
        if (!v[CW-1])
            m = (v + 34'sd32768) >>> 16;
        else
            m = -((-v + 34'sd32768) >>> 16);
        if (m > 34'sd16384)
            m = 34'sd16384;
        else if (m < -34'sd16384)
            m = -34'sd16384;
        return 16'(m);
    endfunction

    logic [STAGES+1:0]     v_reg;
    cmvg_pkg::trig_side_t  side_reg [STAGES+2];
    logic [LANES-1:0]      neg_reg  [STAGES+1];
    logic signed [CW-1:0]  x_reg    [STAGES+1][LANES];
    logic signed [CW-1:0]  y_reg    [STAGES+1][LANES];
    logic signed [ZW-1:0]  z_reg    [STAGES+1][LANES];
    logic signed [15:0]    s_reg    [LANES];
    logic signed [15:0]    c_reg    [LANES];

    logic signed [ZW-1:0]  z0    [LANES];
    logic [LANES-1:0]      neg0;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (angle[l] >= 26'(3 * cmvg_pkg::QUARTER))
            begin
                z0[l]   = $signed({1'b0, angle[l]}) - 27'(cmvg_pkg::FULL);
                neg0[l] = 1'b0;
            end
            else if (angle[l] > 26'(cmvg_pkg::QUARTER))
            begin
                z0[l]   = $signed({1'b0, angle[l]}) - 27'(cmvg_pkg::HALF);
                neg0[l] = 1'b1;
            end
            else
            begin
                z0[l]   = $signed({1'b0, angle[l]});
                neg0[l] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[STAGES:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            neg_reg[0]  <= neg0;
            for (int l = 0; l < LANES; l++)
            begin
                x_reg[0][l] <= cmvg_pkg::GAIN_Q30;
                y_reg[0][l] <= '0;
                z_reg[0][l] <= z0[l];
            end
        end
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic signed [CW-1:0] xc [LANES][PER+1];
        logic signed [CW-1:0] yc [LANES][PER+1];
        logic signed [ZW-1:0] zc [LANES][PER+1];

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                xc[l][0] = x_reg[s][l];
                yc[l][0] = y_reg[s][l];
                zc[l][0] = z_reg[s][l];
                for (int k = 0; k < PER; k++)
                begin
                    if (!zc[l][k][ZW-1])
                    begin
                        xc[l][k+1] = xc[l][k] - (yc[l][k] >>> (s*PER+k));
                        yc[l][k+1] = yc[l][k] + (xc[l][k] >>> (s*PER+k));
                        zc[l][k+1] = zc[l][k] - cmvg_pkg::ATAN[s*PER+k];
                    end
                    else
                    begin
                        xc[l][k+1] = xc[l][k] + (yc[l][k] >>> (s*PER+k));
                        yc[l][k+1] = yc[l][k] - (xc[l][k] >>> (s*PER+k));
                        zc[l][k+1] = zc[l][k] + cmvg_pkg::ATAN[s*PER+k];
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s+1] <= side_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                for (int l = 0; l < LANES; l++)
                begin
                    x_reg[s+1][l] <= xc[l][PER];
                    y_reg[s+1][l] <= yc[l][PER];
                    z_reg[s+1][l] <= zc[l][PER];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[STAGES+1] <= side_reg[STAGES];
            for (int l = 0; l < LANES; l++)
            begin
                c_reg[l] <= neg_reg[STAGES][l] ? -rnd_q14(x_reg[STAGES][l])
                                               : rnd_q14(x_reg[STAGES][l]);
                s_reg[l] <= neg_reg[STAGES][l] ? -rnd_q14(y_reg[STAGES][l])
                                               : rnd_q14(y_reg[STAGES][l]);
            end
        end
    end

    assign out_valid = v_reg[STAGES+1];
    assign sin_q     = s_reg;
    assign cos_q     = c_reg;
    assign side_out  = side_reg[STAGES+1];

endmodule

// ----- rtl/core/cmvg_atan.sv -----
`timescale 1ns / 1ps

// Vectoring CORDIC: angle of (px, py), py >= 0, as Q16 fraction of pi.
// Half-plane fold in stage 0, three steps per stage, rounding last.
module cmvg_atan
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [18:0]          px,
    input  logic signed [15:0]          py,
    input  cmvg_pkg::vec_side_t         side_in,
    output logic                        out_valid,
    output logic [16:0]                 ang,
    output cmvg_pkg::vec_side_t         side_out
);

    localparam int PER    = 3;
    localparam int STAGES = cmvg_pkg::CORDIC_N / PER;
    localparam int VW     = cmvg_pkg::VEC_W;
    localparam int ZW     = cmvg_pkg::ANG_W;

    function automatic logic [16:0] rnd_q16(input logic signed [ZW-1:0] v);
        logic signed [ZW-1:0] m;
        if (!v[ZW-1])
            m = (v + 27'sd128) >>> 8;
        else
            m = -((-v + 27'sd128) >>> 8);
        if (m < 27'sd0)
            m = '0;
        else if (m > 27'sd65536)
            m = 27'sd65536;
        return 17'(m);
    endfunction

    logic [STAGES+1:0]    v_reg;
    cmvg_pkg::vec_side_t  side_reg [STAGES+2];
    logic signed [VW-1:0] x_reg    [STAGES+1];
    logic signed [VW-1:0] y_reg    [STAGES+1];
    logic signed [ZW-1:0] z_reg    [STAGES+1];
    logic [16:0]          ang_reg;

    logic signed [VW-1:0] x0;
    logic signed [VW-1:0] y0;

    assign x0 = VW'(px) <<< 16;
    assign y0 = VW'(py) <<< 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[STAGES:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            if (x0[VW-1])
            begin
                x_reg[0] <= y0;
                y_reg[0] <= -x0;
                z_reg[0] <= 27'(cmvg_pkg::QUARTER);
            end
            else
            begin
                x_reg[0] <= x0;
                y_reg[0] <= y0;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic signed [VW-1:0] xc [PER+1];
        logic signed [VW-1:0] yc [PER+1];
        logic signed [ZW-1:0] zc [PER+1];

        always_comb
        begin
            xc[0] = x_reg[s];
            yc[0] = y_reg[s];
            zc[0] = z_reg[s];
            for (int k = 0; k < PER; k++)
            begin
                if (!yc[k][VW-1] && (yc[k] != '0))
                begin
                    xc[k+1] = xc[k] + (yc[k] >>> (s*PER+k));
                    yc[k+1] = yc[k] - (xc[k] >>> (s*PER+k));
                    zc[k+1] = zc[k] + cmvg_pkg::ATAN[s*PER+k];
                end
                else
                begin
                    xc[k+1] = xc[k] - (yc[k] >>> (s*PER+k));
                    yc[k+1] = yc[k] + (xc[k] >>> (s*PER+k));
                    zc[k+1] = zc[k] - cmvg_pkg::ATAN[s*PER+k];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s+1] <= side_reg[s];
                x_reg[s+1]    <= xc[PER];
                y_reg[s+1]    <= yc[PER];
                z_reg[s+1]    <= zc[PER];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[STAGES+1] <= side_reg[STAGES];
            ang_reg            <= rnd_q16(z_reg[STAGES]);
        end
    end

    assign out_valid = v_reg[STAGES+1];
    assign ang       = ang_reg;
    assign side_out  = side_reg[STAGES+1];

endmodule

// ----- rtl/core/capsule_mesh_vertex_generator.sv -----
`timescale 1ns / 1ps

// Pipeline order from input beat to result beat: divider, sin/cos, multiply,
// round, texture-v CORDIC, output register.
// Throughput: one vertex per cycle; the pipeline stalls as a whole only when
// the output register holds a beat that m_tready has not taken.
// Reset: clears all valid bits; segments returns to 8, capsule_height to 2.0.
module capsule_mesh_vertex_generator
#(
    parameter int MAX_SEGMENTS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    // config write port
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [17:0]  cfg_data,
    // request: [7:0] column, [15:8] row
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,
    // result: [15:0] pos_x, [34:16] pos_y, [50:35] pos_z, [66:51] norm_x,
    // [82:67] norm_y, [98:83] norm_z, [115:99] tex_u, [132:116] tex_v,
    // [148:133] tan_x, [164:149] tan_z, [167:165] zero
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,
    // [0] index_error
    output logic         m_tuser
);

    // ---------------- configuration ----------------
    logic [6:0]  seg_reg;
    logic [17:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg    <= 7'd8;
            height_reg <= 18'd32768;
        end
        else if (cfg_we)
        begin
            unique case (cmvg_pkg::cfg_idx_t'(cfg_addr))
                cmvg_pkg::CFG_SEGMENTS: seg_reg    <= cfg_data[6:0];
                cmvg_pkg::CFG_HEIGHT:   height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // One enable for every stage: the pipeline moves whenever the output
    // register is empty or being drained.
    logic en;
    logic out_v_reg;

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    // ---------------- request decode ----------------
    logic [7:0] col;
    logic [7:0] row;
    logic [6:0] n_eff;
    logic [7:0] d2n;
    logic       err_in;
    logic       upper_in;
    logic [7:0] jp;

    assign col   = s_tdata[7:0];
    assign row   = s_tdata[15:8];
    // segments saturate at MAX_SEGMENTS
    assign n_eff = (32'(seg_reg) > MAX_SEGMENTS) ? 7'(MAX_SEGMENTS) : seg_reg;
    assign d2n   = {n_eff, 1'b0};

    // empty grid or index past the last column / row
    assign err_in   = (n_eff == 7'd0) || (col > d2n) ||
                      ({1'b0, row} > ({1'b0, d2n} + 9'd1));
    assign upper_in = (row <= {1'b0, n_eff});
    // lower hemisphere repeats the equator row, so shift it down by one
    assign jp       = upper_in ? row : (row - 8'd1);

    // ---------------- divider ----------------
    // lane 0: phi   = (i*2^25 + n)   / 2n
    // lane 1: theta = (j'*2^25 + 2n) / 2n, halved
    // lane 2: u     = (i*2^25 + n*2^9) / 2n, over 2^9
    logic [7:0]           div_a  [cmvg_pkg::DIV_LANES];
    logic [24:0]          div_lo [cmvg_pkg::DIV_LANES];
    logic [25:0]          div_q  [cmvg_pkg::DIV_LANES];
    logic                 div_v;
    cmvg_pkg::div_side_t  div_side_in;
    cmvg_pkg::div_side_t  div_side;

    assign div_a[0]  = col;
    assign div_a[1]  = jp;
    assign div_a[2]  = col;
    assign div_lo[0] = 25'(n_eff);
    assign div_lo[1] = 25'(d2n);
    assign div_lo[2] = 25'({n_eff, 9'd0});

    assign div_side_in.err   = err_in;
    assign div_side_in.upper = upper_in;

    cmvg_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .a         (div_a),
        .lo        (div_lo),
        .d         (d2n),
        .side_in   (div_side_in),
        .out_valid (div_v),
        .q         (div_q),
        .side_out  (div_side)
    );

    // ---------------- sine / cosine of phi and theta ----------------
    logic [25:0]           trig_angle [2];
    logic signed [15:0]    trig_sin   [2];
    logic signed [15:0]    trig_cos   [2];
    logic                  trig_v;
    cmvg_pkg::trig_side_t  trig_side_in;
    cmvg_pkg::trig_side_t  trig_side;

    assign trig_angle[0]      = div_q[0];
    assign trig_angle[1]      = {1'b0, div_q[1][25:1]};
    assign trig_side_in.err   = div_side.err;
    assign trig_side_in.upper = div_side.upper;
    assign trig_side_in.tex_u = div_q[2][25:9];

    cmvg_sincos u_sincos
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_v),
        .angle     (trig_angle),
        .side_in   (trig_side_in),
        .out_valid (trig_v),
        .sin_q     (trig_sin),
        .cos_q     (trig_cos),
        .side_out  (trig_side)
    );

    // ---------------- multiply stage ----------------
    // sin(theta) times sin(phi) / cos(phi), full Q28 products
    logic                  mul_v_reg;
    cmvg_pkg::trig_side_t  mul_side_reg;
    logic signed [31:0]    prx_reg;
    logic signed [31:0]    prz_reg;
    logic signed [15:0]    ct_m_reg;
    logic signed [15:0]    st_m_reg;
    logic signed [15:0]    cp_m_reg;
    logic signed [15:0]    sp_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_v_reg <= 1'b0;
        else if (en)
            mul_v_reg <= trig_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_side_reg <= trig_side;
            prx_reg      <= trig_sin[1] * trig_sin[0];
            prz_reg      <= trig_sin[1] * trig_cos[0];
            ct_m_reg     <= trig_cos[1];
            st_m_reg     <= trig_sin[1];
            cp_m_reg     <= trig_cos[0];
            sp_m_reg     <= trig_sin[0];
        end
    end

    // ---------------- round stage ----------------
    function automatic logic signed [15:0] rnd_prod(input logic signed [31:0] v);
        logic signed [31:0] m;
        if (!v[31])
            m = (v + 32'sd8192) >>> 14;
        else
            m = -((-v + 32'sd8192) >>> 14);
        return 16'(m);
    endfunction

    logic                 rnd_v_reg;
    cmvg_pkg::vec_side_t  rnd_side_reg;
    logic signed [15:0]   st_r_reg;
    cmvg_pkg::vec_side_t  rnd_side_next;
    logic [18:0]          half_h;

    // floor(h/2); added above the equator, taken off below it
    assign half_h = 19'({1'b0, height_reg[17:1]});

    always_comb
    begin
        rnd_side_next.err   = mul_side_reg.err;
        rnd_side_next.tex_u = mul_side_reg.tex_u;
        rnd_side_next.px    = rnd_prod(prx_reg);
        rnd_side_next.pz    = rnd_prod(prz_reg);
        rnd_side_next.py    = mul_side_reg.upper ? (19'(ct_m_reg) + half_h)
                                                 : (19'(ct_m_reg) - half_h);
        rnd_side_next.ct    = ct_m_reg;
        rnd_side_next.cp    = cp_m_reg;
        rnd_side_next.nsp   = -sp_m_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rnd_v_reg <= 1'b0;
        else if (en)
            rnd_v_reg <= mul_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_side_reg <= rnd_side_next;
            st_r_reg     <= st_m_reg;
        end
    end

    // ---------------- texture v ----------------
    logic                 vec_v;
    logic [16:0]          vec_ang;
    cmvg_pkg::vec_side_t  vec_side;

    cmvg_atan u_atan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rnd_v_reg),
        .px        (rnd_side_reg.py),
        .py        (st_r_reg),
        .side_in   (rnd_side_reg),
        .out_valid (vec_v),
        .ang       (vec_ang),
        .side_out  (vec_side)
    );

    // ---------------- output register ----------------
    logic [167:0] out_data_reg;
    logic         out_err_reg;
    logic [167:0] out_data_next;

    always_comb
    begin
        if (vec_side.err)
            out_data_next = '0;
        else
            out_data_next = {3'd0, vec_side.nsp, vec_side.cp, vec_ang, vec_side.tex_u,
                             vec_side.pz, vec_side.ct, vec_side.px, vec_side.pz,
                             vec_side.py, vec_side.px};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= vec_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_err_reg  <= vec_side.err;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("index error beat carries nonzero data");

    a_norm_eq_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[66:51] == m_tdata[15:0]) &&
                      (m_tdata[98:83] == m_tdata[50:35])))
        else $error("normal x/z differ from position x/z");

    a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[115:99] <= 17'd65536) &&
                      (m_tdata[132:116] <= 17'd65536)))
        else $error("texture coordinate out of range");

    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("request taken while pipeline is stalled");
`endif

endmodule
